// ===== design/ffba_pkg.sv =====
package ffba_pkg;

	localparam int HEAP_BYTES = 1048576;
	localparam int MAX_BLOCKS = 64;
	localparam int HDR_BYTES  = 32;
	localparam int MIN_REMAIN = 64;

	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	localparam int RSZ_W  = SIZE_W + 1;
	localparam int CMP_W  = SIZE_W + 2;
	localparam int ST_W   = 3;
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
	localparam logic [ST_W-1:0] ST_NOMEM   = 3'd2;
	localparam logic [ST_W-1:0] ST_INVALID = 3'd3;
	localparam logic [ST_W-1:0] ST_DFREE   = 3'd4;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              free;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_INIT,
		CMD_LOAD,
		CMD_RD_IDX,
		CMD_FAIL,
		CMD_TAKE,
		CMD_NEXT,
		CMD_SPLIT_BEGIN,
		CMD_SH_RD,
		CMD_SH_WR,
		CMD_SPLIT_NEW,
		CMD_ALLOC_WR,
		CMD_DFREE,
		CMD_MARK,
		CMD_RD_NEXT,
		CMD_MERGE_NEXT,
		CMD_RM_RD,
		CMD_RM_WR,
		CMD_CNT_DEC,
		CMD_RD_PREV,
		CMD_MERGE_PREV
	} cmd_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_CHK,
		S_ALLOC,
		S_SH_RD,
		S_SH_WR,
		S_AWR,
		S_FREE,
		S_NX_RD,
		S_NX_CHK,
		S_RN_RD,
		S_RN_WR,
		S_PV_RD,
		S_PV_CHK,
		S_RP_RD,
		S_RP_WR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic in_skip;
		logic op_alloc;
		logic at_end;
		logic hit;
		logic split;
		logic cur_free;
		logic has_next;
		logic has_prev;
		logic nb_free;
		logic sh_more;
		logic rm_more;
	} sts_t;

endpackage

// ===== design/ffba_req_if.sv =====
interface ffba_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [ffba_pkg::SIZE_W-1:0] request_bytes;
	logic [ffba_pkg::ADDR_W-1:0] block_address;

	modport source (output valid, req_type, request_bytes, block_address, input ready);
	modport sink (input valid, req_type, request_bytes, block_address, output ready);
endinterface

// ===== design/ffba_rsp_if.sv =====
interface ffba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ffba_pkg::ADDR_W-1:0] address;
	logic [ffba_pkg::ST_W-1:0]   status;
	logic [ffba_pkg::SIZE_W-1:0] used_bytes;
	logic [ffba_pkg::SIZE_W-1:0] free_bytes;

	modport source (output valid, address, status, used_bytes, free_bytes, input ready);
	modport sink (input valid, address, status, used_bytes, free_bytes, output ready);
endinterface

// ===== design/ffba_ram.sv =====
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/ffba_ctrl.sv =====
module ffba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	input  ffba_pkg::sts_t  sts,
	output ffba_pkg::cmd_t  cmd,
	output logic            in_ready,
	output logic            out_valid
);

	ffba_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ffba_pkg::S_INIT: state_nx = ffba_pkg::S_IDLE;
			ffba_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = sts.in_skip ? ffba_pkg::S_OUT : ffba_pkg::S_RD;
				end
			end
			ffba_pkg::S_RD: state_nx = sts.at_end ? ffba_pkg::S_OUT : ffba_pkg::S_CHK;
			ffba_pkg::S_CHK: begin
				if (sts.hit) begin
					state_nx = sts.op_alloc ? ffba_pkg::S_ALLOC : ffba_pkg::S_FREE;
				end else begin
					state_nx = ffba_pkg::S_RD;
				end
			end
			ffba_pkg::S_ALLOC: state_nx = sts.split ? ffba_pkg::S_SH_RD : ffba_pkg::S_OUT;
			ffba_pkg::S_SH_RD: state_nx = sts.sh_more ? ffba_pkg::S_SH_WR : ffba_pkg::S_AWR;
			ffba_pkg::S_SH_WR: state_nx = ffba_pkg::S_SH_RD;
			ffba_pkg::S_AWR: state_nx = ffba_pkg::S_OUT;
			ffba_pkg::S_FREE: begin
				if (sts.cur_free) begin
					state_nx = ffba_pkg::S_OUT;
				end else begin
					state_nx = sts.has_next ? ffba_pkg::S_NX_RD : ffba_pkg::S_PV_RD;
				end
			end
			ffba_pkg::S_NX_RD: state_nx = ffba_pkg::S_NX_CHK;
			ffba_pkg::S_NX_CHK: state_nx = sts.nb_free ? ffba_pkg::S_RN_RD : ffba_pkg::S_PV_RD;
			ffba_pkg::S_RN_RD: state_nx = sts.rm_more ? ffba_pkg::S_RN_WR : ffba_pkg::S_PV_RD;
			ffba_pkg::S_RN_WR: state_nx = ffba_pkg::S_RN_RD;
			ffba_pkg::S_PV_RD: state_nx = sts.has_prev ? ffba_pkg::S_PV_CHK : ffba_pkg::S_OUT;
			ffba_pkg::S_PV_CHK: state_nx = sts.nb_free ? ffba_pkg::S_RP_RD : ffba_pkg::S_OUT;
			ffba_pkg::S_RP_RD: state_nx = sts.rm_more ? ffba_pkg::S_RP_WR : ffba_pkg::S_OUT;
			ffba_pkg::S_RP_WR: state_nx = ffba_pkg::S_RP_RD;
			ffba_pkg::S_OUT: begin
				if (out_ready) begin
					state_nx = ffba_pkg::S_IDLE;
				end
			end
			default: state_nx = ffba_pkg::S_INIT;
		endcase
	end

	always_comb begin
		cmd       = ffba_pkg::CMD_NOP;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ffba_pkg::S_INIT: cmd = ffba_pkg::CMD_INIT;
			ffba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = ffba_pkg::CMD_LOAD;
				end
			end
			ffba_pkg::S_RD: cmd = sts.at_end ? ffba_pkg::CMD_FAIL : ffba_pkg::CMD_RD_IDX;
			ffba_pkg::S_CHK: cmd = sts.hit ? ffba_pkg::CMD_TAKE : ffba_pkg::CMD_NEXT;
			ffba_pkg::S_ALLOC: begin
				cmd = sts.split ? ffba_pkg::CMD_SPLIT_BEGIN : ffba_pkg::CMD_ALLOC_WR;
			end
			ffba_pkg::S_SH_RD: cmd = sts.sh_more ? ffba_pkg::CMD_SH_RD : ffba_pkg::CMD_SPLIT_NEW;
			ffba_pkg::S_SH_WR: cmd = ffba_pkg::CMD_SH_WR;
			ffba_pkg::S_AWR: cmd = ffba_pkg::CMD_ALLOC_WR;
			ffba_pkg::S_FREE: cmd = sts.cur_free ? ffba_pkg::CMD_DFREE : ffba_pkg::CMD_MARK;
			ffba_pkg::S_NX_RD: cmd = ffba_pkg::CMD_RD_NEXT;
			ffba_pkg::S_NX_CHK: begin
				cmd = sts.nb_free ? ffba_pkg::CMD_MERGE_NEXT : ffba_pkg::CMD_NOP;
			end
			ffba_pkg::S_RN_RD,
			ffba_pkg::S_RP_RD: cmd = sts.rm_more ? ffba_pkg::CMD_RM_RD : ffba_pkg::CMD_CNT_DEC;
			ffba_pkg::S_RN_WR,
			ffba_pkg::S_RP_WR: cmd = ffba_pkg::CMD_RM_WR;
			ffba_pkg::S_PV_RD: cmd = sts.has_prev ? ffba_pkg::CMD_RD_PREV : ffba_pkg::CMD_NOP;
			ffba_pkg::S_PV_CHK: begin
				cmd = sts.nb_free ? ffba_pkg::CMD_MERGE_PREV : ffba_pkg::CMD_NOP;
			end
			ffba_pkg::S_OUT: out_valid = 1'b1;
			default: cmd = ffba_pkg::CMD_NOP;
		endcase
	end

endmodule

// ===== design/ffba_dp.sv =====
module ffba_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffba_pkg::cmd_t              cmd,
	input  logic                        req_type,
	input  logic [ffba_pkg::SIZE_W-1:0] request_bytes,
	input  logic [ffba_pkg::ADDR_W-1:0] block_address,
	output ffba_pkg::sts_t              sts,
	output logic [ffba_pkg::ADDR_W-1:0] address,
	output logic [ffba_pkg::ST_W-1:0]   status,
	output logic [ffba_pkg::SIZE_W-1:0] used_bytes,
	output logic [ffba_pkg::SIZE_W-1:0] free_bytes
);

	logic                        op_q;
	logic [ffba_pkg::RSZ_W-1:0]  rsize_q;
	logic [ffba_pkg::ADDR_W-1:0] paddr_q;
	logic [ffba_pkg::CNT_W-1:0]  idx_q;
	logic [ffba_pkg::CNT_W-1:0]  k_q;
	logic [ffba_pkg::CNT_W-1:0]  cnt_q;
	logic [ffba_pkg::SIZE_W-1:0] used_q;
	ffba_pkg::ent_t              cur_q;
	logic [ffba_pkg::ADDR_W-1:0] addr_q;
	logic [ffba_pkg::ST_W-1:0]   status_q;

	logic                        we;
	logic [ffba_pkg::IDX_W-1:0]  waddr, raddr;
	ffba_pkg::ent_t              wdata;
	logic [ffba_pkg::ENT_W-1:0]  rdata_raw;
	ffba_pkg::ent_t              rd;

	logic [ffba_pkg::CNT_W-1:0]  idx_p1, idx_m1, k_p1, k_m1;
	logic [ffba_pkg::RSZ_W-1:0]  rsize_in;
	logic [ffba_pkg::CMP_W-1:0]  split_lim;
	logic [ffba_pkg::SIZE_W-1:0] merged_next, merged_prev, rem_size;
	logic [ffba_pkg::ADDR_W-1:0] rem_start;
	logic [ffba_pkg::SIZE_W:0]   rd_pay;

	assign idx_p1 = idx_q + 1'b1;
	assign idx_m1 = idx_q - 1'b1;
	assign k_p1   = k_q + 1'b1;
	assign k_m1   = k_q - 1'b1;
	assign rd     = ffba_pkg::ent_t'(rdata_raw);

	assign rsize_in    = ({1'b0, request_bytes} + ffba_pkg::RSZ_W'(15))
	                     & ~ffba_pkg::RSZ_W'(15);
	assign split_lim   = {1'b0, rsize_q}
	                     + ffba_pkg::CMP_W'(ffba_pkg::HDR_BYTES + ffba_pkg::MIN_REMAIN);
	assign merged_next = cur_q.size + ffba_pkg::SIZE_W'(ffba_pkg::HDR_BYTES) + rd.size;
	assign merged_prev = rd.size + ffba_pkg::SIZE_W'(ffba_pkg::HDR_BYTES) + cur_q.size;
	assign rem_size    = cur_q.size - rsize_q[ffba_pkg::SIZE_W-1:0]
	                     - ffba_pkg::SIZE_W'(ffba_pkg::HDR_BYTES);
	assign rem_start   = cur_q.start + ffba_pkg::ADDR_W'(ffba_pkg::HDR_BYTES)
	                     + rsize_q[ffba_pkg::ADDR_W-1:0];
	assign rd_pay      = {1'b0, rd.start} + (ffba_pkg::SIZE_W + 1)'(ffba_pkg::HDR_BYTES);

	always_comb begin
		sts.in_skip  = (req_type == ffba_pkg::REQ_ALLOC) ? (request_bytes == '0)
		                                                 : (block_address == '0);
		sts.op_alloc = (op_q == ffba_pkg::REQ_ALLOC);
		sts.at_end   = (idx_q == cnt_q);
		sts.hit      = sts.op_alloc ? (rd.free && ({1'b0, rd.size} >= rsize_q))
		                            : (rd_pay == {2'b0, paddr_q});
		sts.split    = ({2'b0, cur_q.size} > split_lim)
		               && (cnt_q < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS));
		sts.cur_free = cur_q.free;
		sts.has_next = (idx_p1 < cnt_q);
		sts.has_prev = (idx_q != '0);
		sts.nb_free  = rd.free;
		sts.sh_more  = (k_q > idx_p1);
		sts.rm_more  = (k_p1 < cnt_q);
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[ffba_pkg::IDX_W-1:0];
		wdata = cur_q;
		raddr = idx_q[ffba_pkg::IDX_W-1:0];
		case (cmd)
			ffba_pkg::CMD_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '{start: '0,
				          size: ffba_pkg::SIZE_W'(ffba_pkg::HEAP_BYTES - ffba_pkg::HDR_BYTES),
				          free: 1'b1};
			end
			ffba_pkg::CMD_SH_RD:   raddr = k_m1[ffba_pkg::IDX_W-1:0];
			ffba_pkg::CMD_RD_NEXT: raddr = idx_p1[ffba_pkg::IDX_W-1:0];
			ffba_pkg::CMD_RM_RD:   raddr = k_p1[ffba_pkg::IDX_W-1:0];
			ffba_pkg::CMD_RD_PREV: raddr = idx_m1[ffba_pkg::IDX_W-1:0];
			ffba_pkg::CMD_SH_WR, ffba_pkg::CMD_RM_WR: begin
				we    = 1'b1;
				waddr = k_q[ffba_pkg::IDX_W-1:0];
				wdata = rd;
			end
			ffba_pkg::CMD_SPLIT_NEW: begin
				we    = 1'b1;
				waddr = idx_p1[ffba_pkg::IDX_W-1:0];
				wdata = '{start: rem_start, size: rem_size, free: 1'b1};
			end
			ffba_pkg::CMD_ALLOC_WR: begin
				we    = 1'b1;
				wdata = '{start: cur_q.start, size: cur_q.size, free: 1'b0};
			end
			ffba_pkg::CMD_MARK: begin
				we    = 1'b1;
				wdata = '{start: cur_q.start, size: cur_q.size, free: 1'b1};
			end
			ffba_pkg::CMD_MERGE_NEXT: begin
				we    = 1'b1;
				wdata = '{start: cur_q.start, size: merged_next, free: 1'b1};
			end
			ffba_pkg::CMD_MERGE_PREV: begin
				we    = 1'b1;
				waddr = idx_m1[ffba_pkg::IDX_W-1:0];
				wdata = '{start: rd.start, size: merged_prev, free: 1'b1};
			end
			default: we = 1'b0;
		endcase
	end

	ffba_ram #(
		.WIDTH(ffba_pkg::ENT_W),
		.DEPTH(ffba_pkg::MAX_BLOCKS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= ffba_pkg::CNT_W'(1);
			used_q <= '0;
			idx_q  <= '0;
			k_q    <= '0;
		end else begin
			case (cmd)
				ffba_pkg::CMD_INIT: begin
					cnt_q  <= ffba_pkg::CNT_W'(1);
					used_q <= '0;
				end
				ffba_pkg::CMD_LOAD:        idx_q <= '0;
				ffba_pkg::CMD_NEXT:        idx_q <= idx_p1;
				ffba_pkg::CMD_SPLIT_BEGIN: k_q <= cnt_q;
				ffba_pkg::CMD_SH_WR:       k_q <= k_m1;
				ffba_pkg::CMD_SPLIT_NEW:   cnt_q <= cnt_q + 1'b1;
				ffba_pkg::CMD_ALLOC_WR:    used_q <= used_q + cur_q.size;
				ffba_pkg::CMD_MARK:        used_q <= used_q - cur_q.size;
				ffba_pkg::CMD_MERGE_NEXT:  k_q <= idx_p1;
				ffba_pkg::CMD_RM_WR:       k_q <= k_p1;
				ffba_pkg::CMD_CNT_DEC:     cnt_q <= cnt_q - 1'b1;
				ffba_pkg::CMD_MERGE_PREV:  k_q <= idx_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			ffba_pkg::CMD_LOAD: begin
				op_q     <= req_type;
				rsize_q  <= rsize_in;
				paddr_q  <= block_address;
				addr_q   <= '0;
				status_q <= (req_type == ffba_pkg::REQ_ALLOC && request_bytes == '0)
				            ? ffba_pkg::ST_ZERO : ffba_pkg::ST_OK;
			end
			ffba_pkg::CMD_FAIL: begin
				status_q <= (op_q == ffba_pkg::REQ_ALLOC) ? ffba_pkg::ST_NOMEM
				                                          : ffba_pkg::ST_INVALID;
			end
			ffba_pkg::CMD_TAKE:       cur_q <= rd;
			ffba_pkg::CMD_SPLIT_NEW:  cur_q.size <= rsize_q[ffba_pkg::SIZE_W-1:0];
			ffba_pkg::CMD_ALLOC_WR: begin
				addr_q <= cur_q.start + ffba_pkg::ADDR_W'(ffba_pkg::HDR_BYTES);
			end
			ffba_pkg::CMD_DFREE:      status_q <= ffba_pkg::ST_DFREE;
			ffba_pkg::CMD_MERGE_NEXT: cur_q.size <= merged_next;
			default: ;
		endcase
	end

	assign address    = addr_q;
	assign status     = status_q;
	assign used_bytes = used_q;
	assign free_bytes = ffba_pkg::SIZE_W'(ffba_pkg::HEAP_BYTES) - used_q;

endmodule

// ===== design/first_fit_block_allocator.sv =====
// Channel  Dir  Payload                                   Handshake
// req      in   req_type, request_bytes, block_address    valid/ready
// rsp      out  address, status, used_bytes, free_bytes   valid/ready
//
// One request at a time; the block table sits in a single-port-read RAM.
// Each request scans the table entries in order from the first, and a split or
// merge shifts the later entries by one place, one entry at a time.
// After reset the INIT state writes the initial heap entry before req.ready rises.
// The result is held on rsp until taken; req.ready stays low meanwhile.
module first_fit_block_allocator (
	input logic       clk,
	input logic       arst_n,
	ffba_req_if.sink  req,
	ffba_rsp_if.source rsp
);

	ffba_pkg::cmd_t cmd;
	ffba_pkg::sts_t sts;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.out_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (req.ready),
		.out_valid(rsp.valid)
	);

	ffba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req.req_type),
		.request_bytes(req.request_bytes),
		.block_address(req.block_address),
		.sts          (sts),
		.address      (rsp.address),
		.status       (rsp.status),
		.used_bytes   (rsp.used_bytes),
		.free_bytes   (rsp.free_bytes)
	);

endmodule

// ===== design/ffba_checker.sv =====
module ffba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ffba_pkg::ADDR_W-1:0] address,
	input logic [ffba_pkg::ST_W-1:0]   status,
	input logic [ffba_pkg::SIZE_W-1:0] used_bytes,
	input logic [ffba_pkg::SIZE_W-1:0] free_bytes
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while result pending");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, used_bytes} + {1'b0, free_bytes})
		              == (ffba_pkg::SIZE_W + 1)'(ffba_pkg::HEAP_BYTES))
		else $error("used and free counts disagree");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ffba_pkg::ST_OK |-> address == '0)
		else $error("non-zero address on failure");

	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> address[3:0] == 4'd0)
		else $error("misaligned payload address");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.address   (rsp.address),
	.status    (rsp.status),
	.used_bytes(rsp.used_bytes),
	.free_bytes(rsp.free_bytes)
);

// ===== tb/first_fit_block_allocator_checker.sv =====
module first_fit_block_allocator_checker (
	input  logic   clk,
	input  logic   arst_n,
	ffba_req_if    req,
	ffba_rsp_if    rsp,
	output int     fail_count,
	output int     pending
);
	import ffba_pkg::*;

	typedef struct {
		logic [ADDR_W-1:0] address;
		logic [ST_W-1:0]   status;
		logic [SIZE_W-1:0] used_bytes;
		logic [SIZE_W-1:0] free_bytes;
	} heap_reply_t;

	logic [ADDR_W-1:0] hdr_start [MAX_BLOCKS];
	logic [SIZE_W:0]   payload   [MAX_BLOCKS];
	logic              is_free   [MAX_BLOCKS];
	int                n_blocks;
	logic [SIZE_W:0]   in_use;
	heap_reply_t       replies_due[$];

	task automatic drop_entry(input int idx);
		for (int k = idx; k + 1 < n_blocks; k++) begin
			hdr_start[k] = hdr_start[k+1];
			payload[k]   = payload[k+1];
			is_free[k]   = is_free[k+1];
		end
		n_blocks--;
	endtask

	task automatic add_entry(input int idx, input logic [ADDR_W-1:0] s,
			input logic [SIZE_W:0] sz);
		for (int k = n_blocks; k > idx; k--) begin
			hdr_start[k] = hdr_start[k-1];
			payload[k]   = payload[k-1];
			is_free[k]   = is_free[k-1];
		end
		hdr_start[idx] = s;
		payload[idx]   = sz;
		is_free[idx]   = 1'b1;
		n_blocks++;
	endtask

	task automatic heap_apply(input logic kind, input logic [SIZE_W-1:0] nbytes,
			input logic [ADDR_W-1:0] paddr, output heap_reply_t r);
		logic [SIZE_W:0] rs;
		int i;
		r.address = '0;
		r.status  = ST_OK;
		if (kind == REQ_ALLOC) begin
			if (nbytes == 0) begin
				r.status = ST_ZERO;
			end else begin
				rs = ({1'b0, nbytes} + (SIZE_W+1)'(15)) & ~(SIZE_W+1)'(15);
				r.status = ST_NOMEM;
				for (i = 0; i < n_blocks; i++) begin
					if (is_free[i] && payload[i] >= rs) begin
						if (payload[i] > rs + HDR_BYTES + MIN_REMAIN && n_blocks < MAX_BLOCKS) begin
							add_entry(i + 1, ADDR_W'(hdr_start[i] + HDR_BYTES + rs),
								(SIZE_W+1)'(payload[i] - rs - HDR_BYTES));
							payload[i] = rs;
						end
						is_free[i] = 1'b0;
						in_use += payload[i];
						r.address = ADDR_W'(hdr_start[i] + HDR_BYTES);
						r.status = ST_OK;
						break;
					end
				end
			end
		end else if (paddr != 0) begin
			for (i = 0; i < n_blocks; i++)
				if (ADDR_W'(hdr_start[i] + HDR_BYTES) == paddr && hdr_start[i] + HDR_BYTES < HEAP_BYTES)
					break;
			if (i >= n_blocks) begin
				r.status = ST_INVALID;
			end else if (is_free[i]) begin
				r.status = ST_DFREE;
			end else begin
				is_free[i] = 1'b1;
				in_use -= payload[i];
				if (i + 1 < n_blocks && is_free[i+1]) begin
					payload[i] = (SIZE_W+1)'(payload[i] + HDR_BYTES + payload[i+1]);
					drop_entry(i + 1);
				end
				if (i > 0 && is_free[i-1]) begin
					payload[i-1] = (SIZE_W+1)'(payload[i-1] + HDR_BYTES + payload[i]);
					drop_entry(i);
				end
			end
		end
		r.used_bytes = SIZE_W'(in_use);
		r.free_bytes = SIZE_W'(HEAP_BYTES - in_use);
	endtask

	assign pending = replies_due.size();

	always @(posedge clk or negedge arst_n) begin
		heap_reply_t r, e;
		if (!arst_n) begin
			hdr_start[0] = '0;
			payload[0]   = (SIZE_W+1)'(HEAP_BYTES - HDR_BYTES);
			is_free[0]   = 1'b1;
			n_blocks     = 1;
			in_use       = '0;
			fail_count   = 0;
			replies_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected reply addr=%h st=%0d", $time, rsp.address, rsp.status);
				end else begin
					e = replies_due.pop_front();
					if (rsp.address !== e.address || rsp.status !== e.status
							|| rsp.used_bytes !== e.used_bytes || rsp.free_bytes !== e.free_bytes) begin
						fail_count++;
						$display("%0t: expected addr=%h st=%0d used=%0d free=%0d, got addr=%h st=%0d used=%0d free=%0d",
							$time, e.address, e.status, e.used_bytes, e.free_bytes,
							rsp.address, rsp.status, rsp.used_bytes, rsp.free_bytes);
					end
				end
			end
			if (req.valid && req.ready) begin
				heap_apply(req.req_type, req.request_bytes, req.block_address, r);
				replies_due.push_back(r);
			end
		end
	end
endmodule

// ===== tb/first_fit_block_allocator_test.sv =====
module first_fit_block_allocator_test;
	import ffba_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending;
	int   n_sent, n_alloc, n_free;
	bit   hold_rsp = 1'b0, calm = 1'b0;
	logic [ADDR_W-1:0] handed_out[$];

	ffba_req_if req ();
	ffba_rsp_if rsp ();

	first_fit_block_allocator i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	first_fit_block_allocator_checker i_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

	// record successful allocations so later frees can name real blocks
	always @(posedge clk)
		if (rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.address != 0)
			handed_out.push_back(rsp.address);

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(0, 14)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	task automatic send(input logic kind, input logic [SIZE_W-1:0] nb,
			input logic [ADDR_W-1:0] pa);
		if (!calm && $urandom_range(0, 6) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.req_type      <= kind;
		req.request_bytes <= nb;
		req.block_address <= pa;
		do @(posedge clk); while (!req.ready);
		n_sent++;
		if (kind == REQ_ALLOC) n_alloc++; else n_free++;
	endtask

	task automatic rand_op();
		int q;
		logic [ADDR_W-1:0] a;
		logic [SIZE_W-1:0] nb;
		q = $urandom_range(0, 99);
		if (q < 45) begin
			case ($urandom_range(0, 4))
				0: nb = SIZE_W'($urandom_range(1, 64));
				1: nb = SIZE_W'($urandom_range(1, 4096));
				2: nb = SIZE_W'($urandom_range(1, 65536));
				3: nb = SIZE_W'($urandom_range(0, 1048576));
				default: nb = SIZE_W'($urandom());
			endcase
			send(REQ_ALLOC, nb, ADDR_W'($urandom()));
		end else if (q < 85 && handed_out.size() > 0) begin
			q = $urandom_range(0, handed_out.size() - 1);
			a = handed_out[q];
			handed_out.delete(q);
			send(REQ_FREE, SIZE_W'($urandom()), a);
		end else begin
			a = ADDR_W'($urandom());
			if ($urandom_range(0, 1)) a = a & 20'hFFFF0;
			send(REQ_FREE, SIZE_W'($urandom()), a);
		end
	endtask

	initial begin
		req.valid <= 1'b0;
		req.req_type <= REQ_ALLOC;
		req.request_bytes <= '0;
		req.block_address <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(REQ_ALLOC, 0, 0);
		send(REQ_ALLOC, 1, 20'hFFFFF);
		send(REQ_ALLOC, 16, 0);
		send(REQ_ALLOC, 17, 0);
		send(REQ_ALLOC, 21'h1FFFFF, 0);
		send(REQ_ALLOC, 1048576, 0);
		send(REQ_FREE, 21'h1FFFFF, 0);
		send(REQ_FREE, 0, 20'hFFFFF);
		send(REQ_FREE, 0, 20'h00033);
		send(REQ_FREE, 0, 32);
		send(REQ_FREE, 0, 32);
		send(REQ_FREE, 0, 96);
		send(REQ_ALLOC, 1048576 - 32, 0);
		send(REQ_ALLOC, 5, 0);
		send(REQ_FREE, 0, 32);
		send(REQ_ALLOC, 1048576 - 32 - 96, 0);
		send(REQ_FREE, 0, 32);
		// fill the table so splits are skipped, then release it all
		for (int k = 0; k < 70; k++) send(REQ_ALLOC, SIZE_W'($urandom_range(1, 200)), 0);
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		while (handed_out.size() > 0) send(REQ_FREE, 0, handed_out.pop_front());
		hold_rsp = 1'b1;
		for (int k = 0; k < 250; k++) rand_op();
		calm = 1'b1;
		for (int k = 0; k < 50; k++) rand_op();
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Sent %0d requests (%0d allocate, %0d free), incl. table-full and merge cases",
			n_sent, n_alloc, n_free);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
